// ----- hw/rtl/ajac_pkg.sv -----
// Shared types, constants and helper functions of the audio job admission check.
`default_nettype none

package ajac_pkg;

	localparam int AJAC_MAX_PCM_CODE = 3;

	localparam int ADDR_W = 32;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int CAP_W = 4;
	localparam int SRC_WORD_W = 26;
	localparam int SINK_WORD_W = 22;
	localparam int RATE_W = 17;

	localparam int SRC_CH_LSB = 17;
	localparam int SRC_BITS_LSB = 20;
	localparam int SINK_CH_LSB = 17;
	localparam int SINK_PCM_LSB = 19;

	localparam logic [RATE_W-1:0] RATE_MIN = 17'd8000;
	localparam logic [RATE_W-1:0] RATE_MAX = 17'd96000;
	localparam logic [RATE_W-1:0] RATE_48K = 17'd48000;

	localparam logic [30:0] SRC_LEN_MAX = 31'h7FFFFFFF;

	localparam logic [1:0] FMT_WAV = 2'd0;
	localparam logic [1:0] FMT_FLAC = 2'd1;
	localparam logic [1:0] MODE_MEMORY = 2'd0;
	localparam logic [1:0] MODE_STREAM = 2'd1;

	localparam int CAP_WAV = 0;
	localparam int CAP_FLAC = 1;
	localparam int CAP_STREAM = 2;
	localparam int CAP_RESAMPLE = 3;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_INVALID = 2'd1,
		ST_UNSUPPORTED = 2'd2
	} status_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_READ_BASE = 3'd0,
		CFG_READ_LIMIT = 3'd1,
		CFG_WRITE_BASE = 3'd2,
		CFG_WRITE_LIMIT = 3'd3,
		CFG_CAPABILITY = 3'd4
	} cfg_index_t;

	// Classified job as it travels from the front end to the back end.
	typedef struct packed {
		status_t early_status;
		logic fmt_flac;
		logic stream;
		logic resample;
		logic eng_ready;
		logic [ADDR_W-1:0] src;
		logic [ADDR_W-1:0] src_last;
		logic [ADDR_W-1:0] dst;
		logic [ADDR_W-1:0] dst_last;
	} job_entry_t;

	function automatic logic rate_bad(input logic [RATE_W-1:0] rate);
		rate_bad = (rate != '0) && ((rate < RATE_MIN) || (rate > RATE_MAX));
	endfunction

	function automatic logic stream_rate(input logic [RATE_W-1:0] rate);
		stream_rate = (rate == RATE_48K) || (rate == RATE_MAX);
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ajac_job_if.sv -----
// Job descriptor request channel.
`default_nettype none

interface ajac_job_if import ajac_pkg::*; ();

	logic valid;
	logic ready;
	logic [1:0] audio_format;
	logic [1:0] output_mode;
	logic downmix_enable;
	logic resample_enable;
	logic [ADDR_W-1:0] source_address;
	logic [ADDR_W-1:0] source_length;
	logic [ADDR_W-1:0] dest_address;
	logic [ADDR_W-1:0] dest_capacity;
	logic [SRC_WORD_W-1:0] source_format_word;
	logic [SINK_WORD_W-1:0] sink_format_word;
	logic engine_ready;

	modport source (
		output valid, audio_format, output_mode, downmix_enable, resample_enable,
		output source_address, source_length, dest_address, dest_capacity,
		output source_format_word, sink_format_word, engine_ready,
		input ready
	);

	modport sink (
		input valid, audio_format, output_mode, downmix_enable, resample_enable,
		input source_address, source_length, dest_address, dest_capacity,
		input source_format_word, sink_format_word, engine_ready,
		output ready
	);
endinterface

`default_nettype wire

// ----- hw/rtl/ajac_res_if.sv -----
// Admission result request channel.
`default_nettype none

interface ajac_res_if;
	logic valid;
	logic ready;
	logic [1:0] admission_status;

	modport source (output valid, admission_status, input ready);
	modport sink (input valid, admission_status, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ajac_cfg_if.sv -----
// Configuration register write channel.
`default_nettype none

interface ajac_cfg_if import ajac_pkg::*; ();

	logic valid;
	logic ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ajac_front.sv -----
// Front end: accepts job descriptors and classifies them in two pipeline stages.
`default_nettype none

module ajac_front import ajac_pkg::*; #(
	parameter int MAX_PCM_CODE = AJAC_MAX_PCM_CODE
) (
	input wire logic clk,
	input wire logic arst_n,
	ajac_job_if.sink job,
	output logic out_valid,
	input wire logic out_ready,
	output job_entry_t out_entry
);

	localparam logic [2:0] PcmMax = 3'(MAX_PCM_CODE);

	logic v_s1;
	logic v_s2;
	logic adv_s1;
	logic adv_s2;

	logic [1:0] fmt_s1;
	logic [1:0] mode_s1;
	logic dmx_s1;
	logic rsm_s1;
	logic [ADDR_W-1:0] src_s1;
	logic [ADDR_W-1:0] slen_s1;
	logic [ADDR_W-1:0] dst_s1;
	logic [ADDR_W-1:0] dcap_s1;
	logic [SRC_WORD_W-1:0] sw_s1;
	logic [SINK_WORD_W-1:0] kw_s1;
	logic rdy_s1;
	logic [ADDR_W:0] in_end_s1;
	logic [ADDR_W:0] out_end_s1;

	job_entry_t entry_d;
	job_entry_t entry_s2;

	logic [RATE_W-1:0] in_rate;
	logic [2:0] in_ch;
	logic [5:0] in_bits;
	logic [RATE_W-1:0] out_rate;
	logic [1:0] out_ch;
	logic [2:0] pcm;
	logic bits_ok;
	logic in_past_top;
	logic out_past_top;
	logic disjoint;
	status_t early;

	assign adv_s2 = !v_s2 || out_ready;
	assign adv_s1 = !v_s1 || adv_s2;
	assign job.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= job.valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// Stage 1 registers the fields and forms both buffer end addresses.
	always_ff @(posedge clk) begin
		if (adv_s1 && job.valid) begin
			fmt_s1 <= job.audio_format;
			mode_s1 <= job.output_mode;
			dmx_s1 <= job.downmix_enable;
			rsm_s1 <= job.resample_enable;
			src_s1 <= job.source_address;
			slen_s1 <= job.source_length;
			dst_s1 <= job.dest_address;
			dcap_s1 <= job.dest_capacity;
			sw_s1 <= job.source_format_word;
			kw_s1 <= job.sink_format_word;
			rdy_s1 <= job.engine_ready;
			in_end_s1 <= {1'b0, job.source_address} + {1'b0, job.source_length};
			out_end_s1 <= {1'b0, job.dest_address} + {1'b0, job.dest_capacity};
		end
	end

	assign in_rate = sw_s1[RATE_W-1:0];
	assign in_ch = sw_s1[SRC_CH_LSB +: 3];
	assign in_bits = sw_s1[SRC_BITS_LSB +: 6];
	assign out_rate = kw_s1[RATE_W-1:0];
	assign out_ch = kw_s1[SINK_CH_LSB +: 2];
	assign pcm = kw_s1[SINK_PCM_LSB +: 3];

	// An end address may reach exactly the top of the space but not pass it.
	assign in_past_top = in_end_s1[ADDR_W] && (in_end_s1[ADDR_W-1:0] != '0);
	assign out_past_top = out_end_s1[ADDR_W] && (out_end_s1[ADDR_W-1:0] != '0);
	assign disjoint = (in_end_s1 <= {1'b0, dst_s1}) || (out_end_s1 <= {1'b0, src_s1});

	always_comb begin
		bits_ok = (in_bits inside {6'd0, 6'd8, 6'd16, 6'd24, 6'd32});
		if (fmt_s1 > FMT_FLAC) begin
			early = ST_UNSUPPORTED;
		end else if ((mode_s1 > MODE_STREAM) || (pcm > PcmMax) || (src_s1[1:0] != 2'b00)
				|| (slen_s1 == '0) || (slen_s1 > {1'b0, SRC_LEN_MAX})) begin
			early = ST_INVALID;
		end else if (in_past_top) begin
			early = ST_INVALID;
		end else if (rate_bad(in_rate)) begin
			early = ST_UNSUPPORTED;
		end else if ((in_ch > 3'd2) || !bits_ok || (out_ch > 2'd2) || rate_bad(out_rate)
				|| ((fmt_s1 == FMT_FLAC) && !(in_bits inside {6'd0, 6'd16, 6'd24}))) begin
			early = ST_UNSUPPORTED;
		end else if (rsm_s1 && !stream_rate(out_rate)) begin
			early = ST_UNSUPPORTED;
		end else if (!rsm_s1 && (out_rate != '0) && (in_rate != '0) && (out_rate != in_rate)) begin
			early = ST_UNSUPPORTED;
		end else if (dmx_s1 && ((in_ch == 3'd1) || (out_ch != 2'd1))) begin
			early = ST_UNSUPPORTED;
		end else if (!dmx_s1 && (in_ch == 3'd2) && (out_ch == 2'd1)) begin
			early = ST_UNSUPPORTED;
		end else if ((mode_s1 == MODE_MEMORY) && ((dst_s1[1:0] != 2'b00) || (dcap_s1 == '0)
				|| out_past_top || !disjoint)) begin
			early = ST_INVALID;
		end else if ((mode_s1 == MODE_STREAM) && ((dst_s1 != '0) || (dcap_s1 != '0)
				|| !stream_rate(out_rate))) begin
			early = ST_INVALID;
		end else begin
			early = ST_OK;
		end

		entry_d.early_status = early;
		entry_d.fmt_flac = (fmt_s1 == FMT_FLAC);
		entry_d.stream = (mode_s1 == MODE_STREAM);
		entry_d.resample = rsm_s1;
		entry_d.eng_ready = rdy_s1;
		entry_d.src = src_s1;
		// Once the range checks pass, the last byte always fits in 32 bits.
		entry_d.src_last = in_end_s1[ADDR_W-1:0] - ADDR_W'(1);
		entry_d.dst = dst_s1;
		entry_d.dst_last = out_end_s1[ADDR_W-1:0] - ADDR_W'(1);
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			entry_s2 <= entry_d;
		end
	end

	assign out_valid = v_s2;
	assign out_entry = entry_s2;

endmodule

`default_nettype wire

// ----- hw/rtl/ajac_queue.sv -----
// Short queue of classified jobs between the front end and the back end.
`default_nettype none

module ajac_queue import ajac_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push_valid,
	output logic push_ready,
	input job_entry_t push_entry,
	output logic head_valid,
	input wire logic pop,
	output job_entry_t head_entry
);

	localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);

	job_entry_t mem_q [QUEUE_DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic push;

	assign push_ready = (count_q != CntW'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign push = push_valid && push_ready;
	assign head_entry = mem_q[rd_ptr_q];

	function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] ptr);
		next_ptr = (ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : ptr + PtrW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(QUEUE_DEPTH))
		else $error("queue fill exceeds its depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("pop from an empty queue");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + CntW'(1)))
		else $error("push without pop did not grow the queue");

endmodule

`default_nettype wire

// ----- hw/rtl/ajac_back.sv -----
// Back end: configuration registers, capability, readiness and window checks, result register.
`default_nettype none

module ajac_back import ajac_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	ajac_cfg_if.sink cfg,
	input wire logic head_valid,
	input job_entry_t head_entry,
	output logic pop,
	ajac_res_if.source res
);

	logic [ADDR_W-1:0] rd_win_base_q;
	logic [ADDR_W-1:0] rd_win_limit_q;
	logic [ADDR_W-1:0] wr_win_base_q;
	logic [ADDR_W-1:0] wr_win_limit_q;
	logic [CAP_W-1:0] cap_q;

	logic out_valid_q;
	status_t status_q;
	status_t status_d;
	logic fmt_cap;
	logic read_ok;
	logic write_ok;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_win_base_q <= '0;
			rd_win_limit_q <= '0;
			wr_win_base_q <= '0;
			wr_win_limit_q <= '0;
			cap_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_READ_BASE: begin
					rd_win_base_q <= cfg.data;
				end
				CFG_READ_LIMIT: begin
					rd_win_limit_q <= cfg.data;
				end
				CFG_WRITE_BASE: begin
					wr_win_base_q <= cfg.data;
				end
				CFG_WRITE_LIMIT: begin
					wr_win_limit_q <= cfg.data;
				end
				CFG_CAPABILITY: begin
					cap_q <= cfg.data[CAP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign pop = head_valid && (!out_valid_q || res.ready);

	assign fmt_cap = head_entry.fmt_flac ? cap_q[CAP_FLAC] : cap_q[CAP_WAV];
	assign read_ok = (head_entry.src >= rd_win_base_q) && (head_entry.src_last <= rd_win_limit_q);
	assign write_ok = (head_entry.dst >= wr_win_base_q) && (head_entry.dst_last <= wr_win_limit_q);

	always_comb begin
		if (head_entry.early_status != ST_OK) begin
			status_d = head_entry.early_status;
		end else if (!fmt_cap) begin
			status_d = ST_UNSUPPORTED;
		end else if (head_entry.stream && !cap_q[CAP_STREAM]) begin
			status_d = ST_UNSUPPORTED;
		end else if (head_entry.resample && !cap_q[CAP_RESAMPLE]) begin
			status_d = ST_UNSUPPORTED;
		end else if (!head_entry.eng_ready) begin
			status_d = ST_INVALID;
		end else if (!read_ok) begin
			status_d = ST_INVALID;
		end else if (!head_entry.stream && !write_ok) begin
			status_d = ST_INVALID;
		end else begin
			status_d = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || res.ready) begin
			out_valid_q <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q <= status_d;
		end
	end

	assign res.valid = out_valid_q;
	assign res.admission_status = status_q;

endmodule

`default_nettype wire

// ----- hw/rtl/audio_job_admission_check.sv -----
// Top level of the audio decode job admission check.
// Each job descriptor request yields exactly one admission status (ok, invalid argument or
// not supported) in request order. A new job is accepted every clock cycle while results are
// taken; each job passes in turn through the front-end stages, the job queue and the result
// register before its status becomes valid. When the result is not taken, the two-entry queue
// and the front-end stages keep absorbing jobs until they fill, then job ready drops.
// Configuration writes are accepted every cycle and take effect on the next; they must
// only be issued while no job is in flight.
`default_nettype none

module audio_job_admission_check import ajac_pkg::*; #(
	parameter int MAX_PCM_CODE = AJAC_MAX_PCM_CODE
) (
	input wire logic clk,
	input wire logic arst_n,
	ajac_job_if.sink job,
	ajac_res_if.source result,
	ajac_cfg_if.sink cfg
);

	logic front_valid;
	logic front_ready;
	job_entry_t front_entry;
	logic head_valid;
	logic pop;
	job_entry_t head_entry;

	ajac_front #(
		.MAX_PCM_CODE(MAX_PCM_CODE)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.job(job),
		.out_valid(front_valid),
		.out_ready(front_ready),
		.out_entry(front_entry)
	);

	ajac_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(front_valid),
		.push_ready(front_ready),
		.push_entry(front_entry),
		.head_valid(head_valid),
		.pop(pop),
		.head_entry(head_entry)
	);

	ajac_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.head_valid(head_valid),
		.head_entry(head_entry),
		.pop(pop),
		.res(result)
	);

endmodule

`default_nettype wire
